FILE: sv/rbx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbx_pkg
// Shared types and constants for the relative branch reference scanner.
// ----------------------------------------------------------------------------
package rbx_pkg;

    // width of the running byte position, which saturates at all ones
    localparam int POS_BITS = 32;

    localparam int ADDR_BITS = 5;

    localparam logic [30:0] MASK31 = 31'h7FFF_FFFF;

    // register index within the configuration space, byte address 4*index
    typedef enum logic [2:0] {
        REG_ARCH_MODE    = 3'd0,
        REG_LITTLE_END   = 3'd1,
        REG_TARGET       = 3'd2,
        REG_RANGE_LIMIT  = 3'd3,
        REG_SCAN_FROM    = 3'd4,
        REG_SCAN_TO      = 3'd5,
        REG_FILE_LENGTH  = 3'd6
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ISA_PPC = 2'd0,
        ISA_ARM = 2'd1,
        ISA_X86 = 2'd2
    } arch_t;

    localparam logic [30:0] SCAN_FROM_RESET = 31'd1;
    localparam logic [30:0] SCAN_TO_RESET   = 31'h7FFF_FFFF;

    // arm adjustment (d - 8) / 4 taken from target - i with the delta of one
    // folded in, negative values add 3 before the shift; x86 adjustment d - 5
    localparam logic [33:0] ARM_BIAS     = 34'd7;
    localparam logic [33:0] ARM_BIAS_RND = 34'd4;
    localparam logic [33:0] X86_BIAS     = 34'd5;

    // snapshot of one byte and its window, held between accept and check
    typedef struct packed {
        logic                  start;
        logic [POS_BITS-1:0]   pos;
        logic [3:0][7:0]       win;   // win[0] oldest, win[3] newest
    } stage_t;

endpackage

FILE: sv/relative_branch_xref_scanner_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// relative_branch_xref_scanner_core
// Scans an image byte stream for relative displacements to a target offset.
// ----------------------------------------------------------------------------
// One image byte is taken per clock cycle unless the output stalls. Each byte
// is captured with its three predecessors into an input stage; the following
// cycle the candidate position is range-checked, the displacement is adjusted
// for the architecture, laid out in the chosen byte order and compared with
// the window. A match then enters the output register once that has room;
// bytes without a match produce no output word. Input flow stops only while the
// output register holds a word not taken. Configuration is to be written over
// the APB port only while the scanner is idle; the block does not enforce it.
module relative_branch_xref_scanner_core
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rbx_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,

    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    data_byte,
    input  logic                          stream_start,

    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [30:0]                   match_position,
    output logic signed [31:0]            match_value,
    output logic [30:0]                   match_count
);

    localparam int PB = rbx_pkg::POS_BITS;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [1:0]  arch_mode_reg;
    logic        little_endian_reg;
    logic [30:0] target_reg;
    logic [30:0] range_limit_reg;
    logic [30:0] scan_from_reg;
    logic [30:0] scan_to_reg;
    logic [30:0] file_length_reg;

    logic                  cfg_wr;
    rbx_pkg::cfg_reg_t     cfg_sel;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_sel = rbx_pkg::cfg_reg_t'(paddr[rbx_pkg::ADDR_BITS-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arch_mode_reg     <= rbx_pkg::ISA_PPC;
            little_endian_reg <= 1'b0;
            target_reg        <= '0;
            range_limit_reg   <= '0;
            scan_from_reg     <= rbx_pkg::SCAN_FROM_RESET;
            scan_to_reg       <= rbx_pkg::SCAN_TO_RESET;
            file_length_reg   <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_sel)
                rbx_pkg::REG_ARCH_MODE:   arch_mode_reg     <= pwdata[1:0];
                rbx_pkg::REG_LITTLE_END:  little_endian_reg <= pwdata[0];
                rbx_pkg::REG_TARGET:      target_reg        <= pwdata[30:0];
                rbx_pkg::REG_RANGE_LIMIT: range_limit_reg   <= pwdata[30:0];
                rbx_pkg::REG_SCAN_FROM:   scan_from_reg     <= pwdata[30:0];
                rbx_pkg::REG_SCAN_TO:     scan_to_reg       <= pwdata[30:0];
                rbx_pkg::REG_FILE_LENGTH: file_length_reg   <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            rbx_pkg::REG_ARCH_MODE:   prdata = {30'd0, arch_mode_reg};
            rbx_pkg::REG_LITTLE_END:  prdata = {31'd0, little_endian_reg};
            rbx_pkg::REG_TARGET:      prdata = {1'b0, target_reg};
            rbx_pkg::REG_RANGE_LIMIT: prdata = {1'b0, range_limit_reg};
            rbx_pkg::REG_SCAN_FROM:   prdata = {1'b0, scan_from_reg};
            rbx_pkg::REG_SCAN_TO:     prdata = {1'b0, scan_to_reg};
            rbx_pkg::REG_FILE_LENGTH: prdata = {1'b0, file_length_reg};
            default:                  prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // byte history, position and input stage
    // ------------------------------------------------------------------
    logic [2:0][7:0]     hist_reg, hist_next;     // hist[0] newest
    logic [PB-1:0]       pos_reg, pos_next;
    rbx_pkg::stage_t     s1_reg, s1_next;
    logic                s1_valid_reg, s1_valid_next;

    logic                in_acc;
    logic                advance;
    logic [2:0][7:0]     hist_used;
    logic [PB-1:0]       pos_used;

    assign advance  = s1_valid_reg & (~out_valid | out_ready);
    assign in_ready = ~s1_valid_reg | advance;
    assign in_acc   = in_valid & in_ready;

    always_comb
    begin
        hist_used = stream_start ? '0 : hist_reg;
        pos_used  = stream_start ? '0 : pos_reg;

        hist_next = hist_reg;
        pos_next  = pos_reg;
        s1_next   = s1_reg;
        if (in_acc)
        begin
            hist_next = {hist_used[1], hist_used[0], data_byte};
            pos_next  = (pos_used == '1) ? pos_used : pos_used + PB'(1);
            s1_next.start = stream_start;
            s1_next.pos   = pos_used;
            s1_next.win   = {data_byte, hist_used[0], hist_used[1], hist_used[2]};
        end

        if (in_acc)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg     <= '0;
            pos_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            hist_reg     <= hist_next;
            pos_reg      <= pos_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
    end

    // ------------------------------------------------------------------
    // candidate check
    // ------------------------------------------------------------------
    logic            arch_ok;
    logic            is_arm;
    logic            is_x86;
    logic [2:0]      lag;
    logic [31:0]     pat_size;
    logic [33:0]     delta;
    logic [PB-1:0]   cand;
    logic [63:0]     cand_wide;
    logic            cand_ok;
    logic [30:0]     cand_i;
    logic            bounds_ok;
    logic [33:0]     diff;
    logic [33:0]     disp;
    logic [33:0]     disp_mag;
    logic            range_ok;
    logic [33:0]     arm_t;
    logic [33:0]     arm_r;
    logic [33:0]     adj;
    logic [31:0]     adj_u;
    logic [3:0][7:0] lay;
    logic            bytes_ok;
    logic            hit;

    always_comb
    begin
        arch_ok  = 1'b1;
        is_arm   = 1'b0;
        is_x86   = 1'b0;
        lag      = 3'd3;
        pat_size = 32'd3;
        delta    = 34'd1;
        unique case (arch_mode_reg)
            rbx_pkg::ISA_PPC:
            begin
                lag = 3'd3;
            end
            rbx_pkg::ISA_ARM:
            begin
                lag    = 3'd1;
                is_arm = 1'b1;
            end
            rbx_pkg::ISA_X86:
            begin
                lag      = 3'd4;
                pat_size = 32'd4;
                delta    = 34'd0;
                is_x86   = 1'b1;
            end
            default:
            begin
                arch_ok = 1'b0;
            end
        endcase

        cand      = s1_reg.pos - PB'(lag);
        cand_wide = 64'(cand);
        cand_ok   = (s1_reg.pos != '1) && (s1_reg.pos >= PB'(lag))
                    && (cand_wide <= 64'(rbx_pkg::MASK31));
        cand_i    = 31'(cand_wide);

        bounds_ok = (cand_i >= scan_from_reg) && (cand_i < scan_to_reg)
                    && (({1'b0, cand_i} + pat_size) < {1'b0, file_length_reg});

        // two's complement displacement, bit 33 is the sign
        diff     = {3'b000, target_reg} - {3'b000, cand_i};
        disp     = diff + delta;
        disp_mag = disp[33] ? (34'd0 - disp) : disp;
        range_ok = (range_limit_reg == '0) || (disp_mag <= {3'b000, range_limit_reg});

        // arm divide by four truncates toward zero, both roundings in parallel
        arm_t = diff - rbx_pkg::ARM_BIAS;
        arm_r = arm_t[33] ? (diff - rbx_pkg::ARM_BIAS_RND) : arm_t;
        if (is_arm)
            adj = {arm_r[33], arm_r[33], arm_r[33:2]};
        else if (is_x86)
            adj = diff - rbx_pkg::X86_BIAS;
        else
            adj = disp;
        adj_u = adj[31:0];

        for (int k = 0; k < 4; k++)
        begin
            lay[k] = little_endian_reg ? adj_u[8*k +: 8] : adj_u[8*(3-k) +: 8];
        end

        if (is_x86)
            bytes_ok = (lay[0] == s1_reg.win[0]) && (lay[1] == s1_reg.win[1])
                       && (lay[2] == s1_reg.win[2]) && (lay[3] == s1_reg.win[3]);
        else if (is_arm)
            bytes_ok = (lay[0] == s1_reg.win[1]) && (lay[1] == s1_reg.win[2])
                       && (lay[2] == s1_reg.win[3]);
        else
            bytes_ok = (lay[1] == s1_reg.win[1]) && (lay[2] == s1_reg.win[2])
                       && (lay[3] == s1_reg.win[3]);

        hit = arch_ok & cand_ok & bounds_ok & range_ok & bytes_ok;
    end

    // ------------------------------------------------------------------
    // match count and output register
    // ------------------------------------------------------------------
    logic [30:0] count_reg, count_next;
    logic [30:0] count_base;
    logic        out_valid_reg, out_valid_next;
    logic [30:0] pos_out_reg, pos_out_next;
    logic [31:0] value_out_reg, value_out_next;
    logic [30:0] count_out_reg, count_out_next;

    always_comb
    begin
        count_base = s1_reg.start ? '0 : count_reg;
        count_next = count_reg;
        if (advance)
        begin
            if (hit && (count_base != rbx_pkg::MASK31))
                count_next = count_base + 31'd1;
            else
                count_next = count_base;
        end

        pos_out_next   = pos_out_reg;
        value_out_next = value_out_reg;
        count_out_next = count_out_reg;
        if (advance && hit)
        begin
            pos_out_next   = cand_i - {30'd0, is_arm};
            value_out_next = disp[31:0];
            count_out_next = count_next;
        end

        if (advance)
            out_valid_next = hit;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_out_reg   <= pos_out_next;
        value_out_reg <= value_out_next;
        count_out_reg <= count_out_next;
    end

    assign out_valid      = out_valid_reg;
    assign match_position = pos_out_reg;
    assign match_value    = $signed(value_out_reg);
    assign match_count    = count_out_reg;

endmodule
